// ===== sv/qwsl_pkg.sv =====
// Package for the quarter-wave sine/cosine interpolator: constants, register map, quarter-wave ROM.
package qwsl_pkg;

  localparam int DEF_PHASE_BITS = 16;
  localparam int DEF_OUT_BITS   = 16;
  localparam int MAX_INTERVALS  = 64;
  localparam int ROM_AW         = 7;
  localparam int ROM_DW         = 16;
  localparam int TSEL_W         = 2;

  // register map, indexed by paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic [TSEL_W-1:0] TSEL_RESET = 2'd3;

  // full quarter turn, in ROM units
  localparam logic [ROM_DW-1:0] ROM_ONE = 16'd32768;

  // round(32768 * sin(k*pi/128)); out-of-range index clamps to the last point
  function automatic logic [ROM_DW-1:0] qwsl_rom(input logic [ROM_AW-1:0] k);
    logic [ROM_DW-1:0] r;
    case (k)
      7'd0:  r = 16'd0;     7'd1:  r = 16'd804;   7'd2:  r = 16'd1608;  7'd3:  r = 16'd2411;
      7'd4:  r = 16'd3212;  7'd5:  r = 16'd4011;  7'd6:  r = 16'd4808;  7'd7:  r = 16'd5602;
      7'd8:  r = 16'd6393;  7'd9:  r = 16'd7180;  7'd10: r = 16'd7962;  7'd11: r = 16'd8740;
      7'd12: r = 16'd9512;  7'd13: r = 16'd10279; 7'd14: r = 16'd11039; 7'd15: r = 16'd11793;
      7'd16: r = 16'd12540; 7'd17: r = 16'd13279; 7'd18: r = 16'd14010; 7'd19: r = 16'd14733;
      7'd20: r = 16'd15447; 7'd21: r = 16'd16151; 7'd22: r = 16'd16846; 7'd23: r = 16'd17531;
      7'd24: r = 16'd18205; 7'd25: r = 16'd18868; 7'd26: r = 16'd19520; 7'd27: r = 16'd20160;
      7'd28: r = 16'd20788; 7'd29: r = 16'd21403; 7'd30: r = 16'd22006; 7'd31: r = 16'd22595;
      7'd32: r = 16'd23170; 7'd33: r = 16'd23732; 7'd34: r = 16'd24279; 7'd35: r = 16'd24812;
      7'd36: r = 16'd25330; 7'd37: r = 16'd25833; 7'd38: r = 16'd26320; 7'd39: r = 16'd26791;
      7'd40: r = 16'd27246; 7'd41: r = 16'd27684; 7'd42: r = 16'd28106; 7'd43: r = 16'd28511;
      7'd44: r = 16'd28899; 7'd45: r = 16'd29269; 7'd46: r = 16'd29622; 7'd47: r = 16'd29957;
      7'd48: r = 16'd30274; 7'd49: r = 16'd30572; 7'd50: r = 16'd30853; 7'd51: r = 16'd31114;
      7'd52: r = 16'd31357; 7'd53: r = 16'd31581; 7'd54: r = 16'd31786; 7'd55: r = 16'd31972;
      7'd56: r = 16'd32138; 7'd57: r = 16'd32286; 7'd58: r = 16'd32413; 7'd59: r = 16'd32522;
      7'd60: r = 16'd32610; 7'd61: r = 16'd32679; 7'd62: r = 16'd32729; 7'd63: r = 16'd32758;
      default: r = ROM_ONE;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/quarter_wave_sine_lerp_top.sv =====
// Top level: four-stage pipelined quarter-wave sine/cosine with linear interpolation.
//
// Input channel (in_valid/in_ready): angle_phase, one full turn across its range,
// and func (0 = sine, 1 = cosine). Output channel (out_valid/out_ready): value,
// signed Q1.(OUT_BITS-1), saturated at positive full scale.
// From request acceptance to out_valid a request passes phase fold, ROM
// lookup, interpolation multiply, round/scale/sign. Throughput is one
// request per cycle while the receiver does not stall; every stage holds a
// valid bit and moves whenever the stage after it is empty or moving.
// When the receiver stalls, the output register holds; upstream stages keep
// filling until all four are full, then in_ready drops. Nothing is dropped.
// APB register 0 (table_size_select) picks 8/16/32/64 table intervals; write it
// only while the pipeline is empty.
// Reset (rst, synchronous) empties the pipeline and sets table_size_select to 3.
module quarter_wave_sine_lerp_top
  import qwsl_pkg::*;
#(
  parameter int PHASE_BITS = DEF_PHASE_BITS,
  parameter int OUT_BITS   = DEF_OUT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [PHASE_BITS-1:0]      angle_phase,
  input  logic                       func,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int QB   = PHASE_BITS - 2;
  localparam int PW   = ROM_DW + QB;
  localparam int SHL  = (OUT_BITS >= 16) ? OUT_BITS - 16 : 0;
  localparam int SHR  = (OUT_BITS < 16) ? 16 - OUT_BITS : 0;
  localparam int MW   = 17 + SHL;
  localparam logic [QB:0]           QTURN = (QB+1)'(1) << QB;
  localparam logic [PHASE_BITS-1:0] QADD  = PHASE_BITS'(1) << QB;
  localparam logic [PW:0]           HALF  = (PW+1)'(1) << (QB - 1);
  localparam logic [16:0]           RND   = 17'((1 << SHR) >> 1);
  localparam logic [OUT_BITS-1:0]   HI    = {1'b0, {(OUT_BITS-1){1'b1}}};

  // configuration
  logic [TSEL_W-1:0] tsel;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tsel <= TSEL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TABLE_SIZE) begin
      tsel <= pwdata[TSEL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_SIZE) begin
      prdata = 32'(tsel);
    end
  end

  // stage enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: quadrant fold
  logic [PHASE_BITS-1:0] phase;
  logic [QB:0]           folded_next;
  logic [QB:0]           s1_folded;
  logic                  s1_neg;

  always_comb begin
    phase = angle_phase + (func ? QADD : '0);
    folded_next = phase[QB] ? (QTURN - {1'b0, phase[QB-1:0]}) : {1'b0, phase[QB-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_folded <= folded_next;
      s1_neg    <= phase[PHASE_BITS-1];
    end
  end

  // stage 2: table index, fraction, ROM points
  logic [5:0]          idx64;
  logic [5:0]          idx_mask;
  logic [ROM_AW-1:0]   ka, kb;
  logic [ROM_AW-1:0]   stride;
  logic [2:0]          fsh;
  logic [ROM_DW-1:0]   ra, rb;
  logic [ROM_DW-1:0]   a_next, d_next;
  logic [QB-1:0]       frac_next;
  logic [ROM_DW-1:0]   s2_a, s2_d;
  logic [QB-1:0]       s2_frac;
  logic                s2_neg;
  logic                s2_quarter;

  always_comb begin
    idx64    = s1_folded[QB-1 -: 6];
    idx_mask = 6'h3f << (2'd3 - tsel);
    ka       = {1'b0, idx64 & idx_mask};
    stride   = 7'd8 >> tsel;
    kb       = ka + stride;
    fsh      = 3'd3 + 3'(tsel);
    ra       = qwsl_rom(ka);
    rb       = qwsl_rom(kb);
    if (s1_folded[QB]) begin
      a_next    = ROM_ONE;
      d_next    = '0;
      frac_next = '0;
    end else begin
      a_next    = ra;
      d_next    = rb - ra;
      frac_next = s1_folded[QB-1:0] << fsh;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_a       <= a_next;
      s2_d       <= d_next;
      s2_frac    <= frac_next;
      s2_neg     <= s1_neg;
      s2_quarter <= s1_folded[QB];
    end
  end

  // stage 3: slope times fraction
  logic [PW-1:0]     s3_prod;
  logic [ROM_DW-1:0] s3_a;
  logic              s3_neg;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_prod <= PW'(s2_d) * PW'(s2_frac);
      s3_a    <= s2_a;
      s3_neg  <= s2_neg;
    end
  end

  // stage 4: round, scale, sign, saturate
  logic [PW:0]           prod_sum;
  logic [16:0]           mag;
  logic [16:0]           mag_rnd;
  logic [MW-1:0]         scaled;
  logic [OUT_BITS-1:0]   value_next;
  logic                  out_neg;

  always_comb begin
    prod_sum = {1'b0, s3_prod} + HALF;
    mag      = {1'b0, s3_a} + 17'(prod_sum >> QB);
    mag_rnd  = (mag + RND) >> SHR;
    scaled   = MW'(mag_rnd) << SHL;
    if (s3_neg) begin
      value_next = ~scaled[OUT_BITS-1:0] + 1'b1;
    end else if (scaled[MW-1:OUT_BITS-1] != '0) begin
      value_next = HI;
    end else begin
      value_next = scaled[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      value   <= value_next;
      out_neg <= s3_neg;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted request did not enter stage 1");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> s1_folded <= QTURN)
    else $error("folded angle beyond a quarter turn");

  a_quarter_flat: assert property (@(posedge clk) disable iff (rst)
    v2 && s2_quarter |-> s2_d == '0 && s2_a == ROM_ONE)
    else $error("quarter turn not mapped to full scale");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_neg |-> !value[OUT_BITS-1])
    else $error("positive half produced a negative value");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !out_ready |-> !in_ready)
    else $error("request accepted into a full pipeline");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for quarter_wave_sine_lerp_top: random and edge-case angles checked against a local fixed-point model.
module tb;
  import qwsl_pkg::*;

  localparam int QTURN = 1 << 14;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] ADDR_TSEL = {REG_TABLE_SIZE, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = {~REG_TABLE_SIZE, 2'b00};

  typedef struct {
    logic [15:0] ph;
    logic fn;
  } angle_req_t;

  typedef struct {
    logic [15:0] ph;
    logic fn;
    logic [TSEL_W-1:0] tsel;
    logic signed [15:0] val;
  } sine_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] angle_phase = '0;
  logic func = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quarter_wave_sine_lerp_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .angle_phase(angle_phase), .func(func),
    .out_valid(out_valid), .out_ready(out_ready), .value(value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // quarter-wave sine points, Q1.15 magnitude
  int sine_pts [0:64] = '{
        0,   804,  1608,  2411,  3212,  4011,  4808,  5602,
     6393,  7180,  7962,  8740,  9512, 10279, 11039, 11793,
    12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
    18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
    23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
    27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
    30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
    32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
    32768
  };

  angle_req_t angle_q[$];
  sine_result_t expected_values[$];
  angle_req_t next_req;
  logic [TSEL_W-1:0] tsel_model = TSEL_RESET;
  logic idling = 1'b1;
  logic req_taken = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int cycles = 0;
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_writes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] sine_cos_value(logic [15:0] ph, logic fn,
                                                        logic [TSEL_W-1:0] tsel);
    logic [15:0] p;
    int n, stride, folded, s, idx, frac, a, b, mag;
    p = fn ? ph + 16'h4000 : ph;
    n = 8 << tsel;
    stride = 64 / n;
    folded = p[14] ? QTURN - int'(p[13:0]) : int'(p[13:0]);
    if (folded >= QTURN) begin
      mag = sine_pts[64];
    end else begin
      s = folded * n;
      idx = s >> 14;
      frac = s & (QTURN - 1);
      a = sine_pts[idx * stride];
      b = sine_pts[(idx + 1) * stride];
      mag = a + (((b - a) * frac + QTURN / 2) >> 14);
    end
    if (p[15]) mag = -mag;
    if (mag > 32767) mag = 32767;
    if (mag < -32768) mag = -32768;
    return mag[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_values.size());
      $display("FAILURE");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (angle_q.size() > 0 && idling && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (angle_q.size() > 0) begin
        next_req = angle_q.pop_front();
        angle_phase <= next_req.ph;
        func <= next_req.fn;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    sine_result_t exp_r;
    sine_result_t acc_r;
    req_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        acc_r.ph = angle_phase;
        acc_r.fn = func;
        acc_r.tsel = tsel_model;
        acc_r.val = sine_cos_value(angle_phase, func, tsel_model);
        expected_values.push_back(acc_r);
        n_requests++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d", value));
        end else begin
          exp_r = expected_values.pop_front();
          if (value !== exp_r.val)
            report_mismatch($sformatf("phase=%h func=%0d tsel=%0d value=%0d want %0d",
                                      exp_r.ph, exp_r.fn, exp_r.tsel, value, exp_r.val));
        end
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TSEL) tsel_model = data[TSEL_W-1:0];
    n_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_table_reg();
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_TSEL;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== 32'(tsel_model))
      report_mismatch($sformatf("table size reg read %h want %0d", got, tsel_model));
  endtask

  task automatic push_angle(input logic [15:0] ph, input logic fn);
    angle_req_t r;
    r.ph = ph;
    r.fn = fn;
    angle_q.push_back(r);
  endtask

  task automatic push_random(input int count);
    logic [15:0] ph;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: ph = 16'(($urandom_range(0, 255) << 8) + $urandom_range(0, 4) - 2);
        1: ph = 16'(($urandom_range(0, 3) << 14) +
                    ($urandom_range(0, 1) ? $urandom_range(0, 2) : QTURN - $urandom_range(1, 3)));
        default: ph = 16'($urandom);
      endcase
      push_angle(ph, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (angle_q.size() != 0 || in_valid || expected_values.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [TSEL_W-1:0] sched [8];
    sched = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0};
    for (int k = 4; k < 8; k++) sched[k] = TSEL_W'($urandom_range(0, 3));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_table_reg();

    // quadrant edges, exact quarter turns, full scale both signs
    foreach (sched[k]) begin
      if (k == 0) begin
        for (int f = 0; f < 2; f++) begin
          push_angle(16'h0000, f[0]);
          push_angle(16'h3FFF, f[0]);
          push_angle(16'h4000, f[0]);
          push_angle(16'h4001, f[0]);
          push_angle(16'h7FFF, f[0]);
          push_angle(16'h8000, f[0]);
          push_angle(16'hBFFF, f[0]);
          push_angle(16'hC000, f[0]);
          push_angle(16'hC001, f[0]);
          push_angle(16'hFFFF, f[0]);
        end
        push_angle(16'h2000, 1'b0);
        push_angle(16'h0100, 1'b1);
        push_angle(16'h0001, 1'b0);
        wait_drained();
        apb_write(ADDR_UNMAPPED, $urandom);
        check_table_reg();
      end
      idling = !(k == 3 || k == 7);
      apb_write(ADDR_TSEL, ($urandom & ~32'h3) | 32'(sched[k]));
      check_table_reg();
      push_random(200);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d requests / %0d results in %0d cycles, %0d register writes",
             n_requests, n_results, cycles, n_writes);
    $display("table sizes 8 to 64, sine and cosine, quadrant and knot edges, random stalls");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
